// ===== design/bfit_pkg.sv =====
// ---------------------------------------------------------------------------
// bfit_pkg: shared types and constants
// state encoding, status and operation codes, register indexes, hash constants
// ---------------------------------------------------------------------------
`default_nettype none

package bfit_pkg;

    localparam int DEF_MAX_VALUE_BYTES = 64;
    localparam int DEF_MAX_ARRAY_LOG2  = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_VALUE_SIZE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_HASHES = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HASH_SEL   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HASH_SEED  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ARRAY_LOG2 = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ABSENT   = 2'd1;
    localparam logic [1:0] STATUS_BADFLAGS = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_TEST   = 1'b1;

    localparam logic HASH_JENKINS = 1'b0;
    localparam logic HASH_DJB2    = 1'b1;

    localparam logic [31:0] JHASH_INIT  = 32'hdeadbeef;
    localparam logic [31:0] GOLDEN      = 32'h9e3779b9;
    localparam logic [31:0] FMIX_C1     = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2     = 32'hc2b2ae35;
    localparam logic [3:0]  JHASH_BLK_END = 4'd11;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_FETCH,
        S_ACC,
        S_MIX,
        S_FINAL,
        S_FMIX,
        S_BIT,
        S_CHECK,
        S_RESP
    } bfit_state_t;

endpackage

`default_nettype wire

// ===== design/bfit_in_if.sv =====
// ---------------------------------------------------------------------------
// bfit_in_if: byte stream channel
// one value byte per transaction with operation and insert flags
// ---------------------------------------------------------------------------
`default_nettype none

interface bfit_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] value_byte;
    logic [1:0] update_flags;

    modport source (output valid, output op, output value_byte, output update_flags,
                    input ready);
    modport sink   (input valid, input op, input value_byte, input update_flags,
                    output ready);
endinterface

`default_nettype wire

// ===== design/bfit_out_if.sv =====
// ---------------------------------------------------------------------------
// bfit_out_if: result channel
// one status per completed value
// ---------------------------------------------------------------------------
`default_nettype none

interface bfit_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       op_done;

    modport source (output valid, output status, output op_done, input ready);
    modport sink   (input valid, input status, input op_done, output ready);
endinterface

`default_nettype wire

// ===== design/bloom_filter_insert_test.sv =====
// ---------------------------------------------------------------------------
// bloom_filter_insert_test: bloom filter with insert and membership test
// collects value bytes, hashes them up to k times with one shared round unit and
// sets or tests the selected bits of a single-bit filter memory
// ---------------------------------------------------------------------------
//  channel     dir   transaction carries
//  byte_ch     in    op, value_byte, update_flags
//  result_ch   out   status, op_done
//  cfg_*       in    write enable, register index, write data
//
//  a byte that does not complete a value leaves the block idle for the next
//  one; a completing byte starts k hash passes on the shared round unit, each
//  made of INIT, FETCH and ACC per byte, the rounds and BIT, plus CHECK for a
//  test, then RESP for the result; jenkins mixes after each 12-byte block
//  before the last one and runs its final at the end, djb2 adds 5 finaliser
//  steps; a test stops at the first clear bit; an insert with nonzero flags
//  goes straight to the result; after reset a clearing pass over all
//  2^MAX_ARRAY_LOG2 filter bits zeroes the filter, no byte is taken meanwhile
//  a waiting result stalls only the next completing value, not partial bytes
// ---------------------------------------------------------------------------
`default_nettype none

module bloom_filter_insert_test #(
    parameter int MAX_VALUE_BYTES = bfit_pkg::DEF_MAX_VALUE_BYTES,
    parameter int MAX_ARRAY_LOG2  = bfit_pkg::DEF_MAX_ARRAY_LOG2
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [bfit_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bfit_pkg::CFG_DATA_W-1:0]  cfg_data,
    bfit_in_if.sink                               byte_ch,
    bfit_out_if.source                            result_ch
);

    localparam int LEN_W  = $clog2(MAX_VALUE_BYTES + 1);
    localparam int BUF_AW = (MAX_VALUE_BYTES > 1) ? $clog2(MAX_VALUE_BYTES) : 1;
    localparam int AW     = MAX_ARRAY_LOG2;
    localparam int DEPTH  = 1 << MAX_ARRAY_LOG2;

    // configuration registers
    logic [6:0]  cfg_vsb_reg;
    logic [3:0]  cfg_k_reg;
    logic        cfg_sel_reg;
    logic [31:0] cfg_seed_reg;
    logic [4:0]  cfg_lg_reg;

    // control state
    bfit_pkg::bfit_state_t state_reg, state_next;
    logic [LEN_W-1:0] byte_count_reg, byte_count_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic [3:0]       blk_reg, blk_next;
    logic [2:0]       step_reg, step_next;
    logic [3:0]       hidx_reg, hidx_next;
    logic [AW-1:0]    clr_reg, clr_next;
    logic             out_valid_reg, out_valid_next;

    // payload state
    logic        op_reg, op_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [31:0] c_reg, c_next;
    logic [31:0] seedm_reg, seedm_next;
    logic [1:0]  out_status_reg;
    logic        out_op_reg;

    // memories
    logic [7:0] buf_mem [MAX_VALUE_BYTES];
    logic [7:0] buf_q;
    logic       filt_mem [DEPTH];
    logic       filt_q;

    // derived configuration
    logic [LEN_W-1:0] eff_len;
    logic [3:0]       eff_k;
    logic [4:0]       eff_lg;
    logic [AW-1:0]    bit_mask;
    logic [AW-1:0]    bit_idx;

    // handshake and sequencing flags
    logic byte_take;
    logic value_done;
    logic last_byte;
    logic last_hash;
    logic out_load;
    logic mem_we;
    logic [AW-1:0] mem_addr;
    logic          mem_wdata;

    // shared round unit
    logic [1:0]  role;
    logic [4:0]  rot;
    logic [31:0] rp, rq, rr, rq_rol;
    logic [31:0] mix_p, mix_q, fin_p;
    logic [31:0] acc_add;

    function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] r);
        logic [63:0] t;
        t = {x, x} << r;
        return t[63:32];
    endfunction

    always_comb
    begin
        if (cfg_vsb_reg == 7'd0)
            eff_len = LEN_W'(1);
        else if (32'(cfg_vsb_reg) > 32'(MAX_VALUE_BYTES))
            eff_len = LEN_W'(MAX_VALUE_BYTES);
        else
            eff_len = LEN_W'(cfg_vsb_reg);
    end

    assign eff_k = (cfg_k_reg == 4'd0) ? 4'd1 : cfg_k_reg;

    always_comb
    begin
        if (cfg_lg_reg < 5'd6)
            eff_lg = 5'd6;
        else if (32'(cfg_lg_reg) > 32'(MAX_ARRAY_LOG2))
            eff_lg = 5'(MAX_ARRAY_LOG2);
        else
            eff_lg = cfg_lg_reg;
    end

    always_comb
    begin
        for (int j = 0; j < AW; j++)
            bit_mask[j] = (32'(j) < 32'(eff_lg));
    end

    assign bit_idx = c_reg[AW-1:0] & bit_mask;

    assign byte_ch.ready = (state_reg == bfit_pkg::S_IDLE);
    assign byte_take     = byte_ch.valid && byte_ch.ready;
    assign value_done    = byte_take && (LEN_W'(byte_count_reg + 1'b1) >= eff_len);
    assign last_byte     = (LEN_W'(pos_reg + 1'b1) == eff_len);
    assign last_hash     = (hidx_reg + 4'd1 == eff_k);
    assign out_load      = (state_reg == bfit_pkg::S_RESP) &&
                           (!out_valid_reg || result_ch.ready);

    // round unit: role picks which of a, b, c play p, q, r
    always_comb
    begin
        if (state_reg == bfit_pkg::S_FINAL)
            role = (step_reg == 3'd0 || step_reg == 3'd3 || step_reg == 3'd6) ? 2'd2 :
                   (step_reg == 3'd1 || step_reg == 3'd4) ? 2'd0 : 2'd1;
        else
            role = (step_reg == 3'd0 || step_reg == 3'd3) ? 2'd0 :
                   (step_reg == 3'd1 || step_reg == 3'd4) ? 2'd1 : 2'd2;
    end

    always_comb
    begin
        case (role)
            2'd0:    begin rp = a_reg; rq = c_reg; rr = b_reg; end
            2'd1:    begin rp = b_reg; rq = a_reg; rr = c_reg; end
            default: begin rp = c_reg; rq = b_reg; rr = a_reg; end
        endcase
    end

    always_comb
    begin
        if (state_reg == bfit_pkg::S_FINAL)
        begin
            case (step_reg)
                3'd0:    rot = 5'd14;
                3'd1:    rot = 5'd11;
                3'd2:    rot = 5'd25;
                3'd3:    rot = 5'd16;
                3'd4:    rot = 5'd4;
                3'd5:    rot = 5'd14;
                default: rot = 5'd24;
            endcase
        end
        else
        begin
            case (step_reg)
                3'd0:    rot = 5'd4;
                3'd1:    rot = 5'd6;
                3'd2:    rot = 5'd8;
                3'd3:    rot = 5'd16;
                3'd4:    rot = 5'd19;
                default: rot = 5'd4;
            endcase
        end
    end

    assign rq_rol  = rol32(rq, rot);
    assign mix_p   = (rp - rq) ^ rq_rol;
    assign mix_q   = rq + rr;
    assign fin_p   = (rp ^ rq) - rq_rol;
    assign acc_add = 32'(buf_q) << {blk_reg[1:0], 3'b000};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bfit_pkg::S_CLEAR:
                if (clr_reg == {AW{1'b1}})
                    state_next = bfit_pkg::S_IDLE;
            bfit_pkg::S_IDLE:
                if (value_done)
                begin
                    if (byte_ch.op == bfit_pkg::OP_INSERT && byte_ch.update_flags != 2'd0)
                        state_next = bfit_pkg::S_RESP;
                    else
                        state_next = bfit_pkg::S_INIT;
                end
            bfit_pkg::S_INIT:
                state_next = bfit_pkg::S_FETCH;
            bfit_pkg::S_FETCH:
                state_next = bfit_pkg::S_ACC;
            bfit_pkg::S_ACC:
                if (last_byte)
                    state_next = (cfg_sel_reg == bfit_pkg::HASH_DJB2) ?
                                 bfit_pkg::S_FMIX : bfit_pkg::S_FINAL;
                else if (cfg_sel_reg == bfit_pkg::HASH_JENKINS &&
                         blk_reg == bfit_pkg::JHASH_BLK_END)
                    state_next = bfit_pkg::S_MIX;
                else
                    state_next = bfit_pkg::S_FETCH;
            bfit_pkg::S_MIX:
                if (step_reg == 3'd5)
                    state_next = bfit_pkg::S_FETCH;
            bfit_pkg::S_FINAL:
                if (step_reg == 3'd6)
                    state_next = bfit_pkg::S_BIT;
            bfit_pkg::S_FMIX:
                if (step_reg == 3'd4)
                    state_next = bfit_pkg::S_BIT;
            bfit_pkg::S_BIT:
                if (op_reg == bfit_pkg::OP_TEST)
                    state_next = bfit_pkg::S_CHECK;
                else
                    state_next = last_hash ? bfit_pkg::S_RESP : bfit_pkg::S_INIT;
            bfit_pkg::S_CHECK:
                if (!filt_q || last_hash)
                    state_next = bfit_pkg::S_RESP;
                else
                    state_next = bfit_pkg::S_INIT;
            bfit_pkg::S_RESP:
                if (out_load)
                    state_next = bfit_pkg::S_IDLE;
            default:
                state_next = bfit_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        byte_count_next = byte_count_reg;
        pos_next        = pos_reg;
        blk_next        = blk_reg;
        step_next       = step_reg;
        hidx_next       = hidx_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        c_next          = c_reg;
        seedm_next      = seedm_reg;
        mem_we          = 1'b0;
        mem_addr        = bit_idx;
        mem_wdata       = 1'b1;
        case (state_reg)
            bfit_pkg::S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = 1'b0;
                clr_next  = clr_reg + 1'b1;
            end
            bfit_pkg::S_IDLE:
                if (byte_take)
                begin
                    if (value_done)
                    begin
                        byte_count_next = '0;
                        op_next         = byte_ch.op;
                        hidx_next       = 4'd0;
                        seedm_next      = cfg_seed_reg;
                        if (byte_ch.op == bfit_pkg::OP_INSERT && byte_ch.update_flags != 2'd0)
                            status_next = bfit_pkg::STATUS_BADFLAGS;
                        else
                            status_next = bfit_pkg::STATUS_OK;
                    end
                    else
                        byte_count_next = LEN_W'(byte_count_reg + 1'b1);
                end
            bfit_pkg::S_INIT:
            begin
                pos_next  = '0;
                blk_next  = 4'd0;
                step_next = 3'd0;
                if (cfg_sel_reg == bfit_pkg::HASH_DJB2)
                    c_next = seedm_reg;
                else
                begin
                    a_next = bfit_pkg::JHASH_INIT + 32'(eff_len) + cfg_seed_reg +
                             32'(hidx_reg);
                    b_next = a_next;
                    c_next = a_next;
                end
            end
            bfit_pkg::S_ACC:
            begin
                pos_next  = LEN_W'(pos_reg + 1'b1);
                step_next = 3'd0;
                if (cfg_sel_reg == bfit_pkg::HASH_DJB2)
                    c_next = (c_reg << 5) + c_reg + 32'(buf_q);
                else
                begin
                    blk_next = (blk_reg == bfit_pkg::JHASH_BLK_END) ? 4'd0 : blk_reg + 4'd1;
                    case (blk_reg[3:2])
                        2'd0:    a_next = a_reg + acc_add;
                        2'd1:    b_next = b_reg + acc_add;
                        default: c_next = c_reg + acc_add;
                    endcase
                end
            end
            bfit_pkg::S_MIX:
            begin
                step_next = step_reg + 3'd1;
                case (role)
                    2'd0:    begin a_next = mix_p; c_next = mix_q; end
                    2'd1:    begin b_next = mix_p; a_next = mix_q; end
                    default: begin c_next = mix_p; b_next = mix_q; end
                endcase
            end
            bfit_pkg::S_FINAL:
            begin
                step_next = step_reg + 3'd1;
                case (role)
                    2'd0:    a_next = fin_p;
                    2'd1:    b_next = fin_p;
                    default: c_next = fin_p;
                endcase
            end
            bfit_pkg::S_FMIX:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:    c_next = c_reg ^ (c_reg >> 16);
                    3'd1:    c_next = c_reg * bfit_pkg::FMIX_C1;
                    3'd2:    c_next = c_reg ^ (c_reg >> 13);
                    3'd3:    c_next = c_reg * bfit_pkg::FMIX_C2;
                    default: c_next = c_reg ^ (c_reg >> 16);
                endcase
            end
            bfit_pkg::S_BIT:
                if (op_reg == bfit_pkg::OP_INSERT)
                begin
                    mem_we = 1'b1;
                    if (!last_hash)
                    begin
                        hidx_next  = hidx_reg + 4'd1;
                        seedm_next = seedm_reg + bfit_pkg::GOLDEN;
                    end
                end
            bfit_pkg::S_CHECK:
                if (!filt_q)
                    status_next = bfit_pkg::STATUS_ABSENT;
                else if (!last_hash)
                begin
                    hidx_next  = hidx_reg + 4'd1;
                    seedm_next = seedm_reg + bfit_pkg::GOLDEN;
                end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (result_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign result_ch.valid   = out_valid_reg;
    assign result_ch.status  = out_status_reg;
    assign result_ch.op_done = out_op_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bfit_pkg::S_CLEAR;
            byte_count_reg <= '0;
            pos_reg        <= '0;
            blk_reg        <= 4'd0;
            step_reg       <= 3'd0;
            hidx_reg       <= 4'd0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            cfg_vsb_reg    <= 7'd4;
            cfg_k_reg      <= 4'd3;
            cfg_sel_reg    <= bfit_pkg::HASH_JENKINS;
            cfg_seed_reg   <= 32'd0;
            cfg_lg_reg     <= 5'd16;
        end
        else
        begin
            state_reg      <= state_next;
            byte_count_reg <= byte_count_next;
            pos_reg        <= pos_next;
            blk_reg        <= blk_next;
            step_reg       <= step_next;
            hidx_reg       <= hidx_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    bfit_pkg::REG_VALUE_SIZE: cfg_vsb_reg  <= cfg_data[6:0];
                    bfit_pkg::REG_NUM_HASHES: cfg_k_reg    <= cfg_data[3:0];
                    bfit_pkg::REG_HASH_SEL:   cfg_sel_reg  <= cfg_data[0];
                    bfit_pkg::REG_HASH_SEED:  cfg_seed_reg <= cfg_data[31:0];
                    bfit_pkg::REG_ARRAY_LOG2: cfg_lg_reg   <= cfg_data[4:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        status_reg <= status_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        seedm_reg  <= seedm_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_op_reg     <= op_reg;
        end
    end

    // value byte buffer
    always_ff @(posedge clk)
    begin
        if (byte_take)
            buf_mem[byte_count_reg[BUF_AW-1:0]] <= byte_ch.value_byte;
        buf_q <= buf_mem[pos_reg[BUF_AW-1:0]];
    end

    // filter bit memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            filt_mem[mem_addr] <= mem_wdata;
        filt_q <= filt_mem[bit_idx];
    end

    // checks
    a_no_write_on_test: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfit_pkg::S_BIT && op_reg == bfit_pkg::OP_TEST) |-> !mem_we)
        else $error("filter written during a test");

    a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == bfit_pkg::S_IDLE && out_valid_reg))
        else $error("result load did not return to idle");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(byte_count_reg) < 32'(MAX_VALUE_BYTES))
        else $error("byte count beyond buffer");

    a_hash_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != bfit_pkg::S_IDLE && state_reg != bfit_pkg::S_CLEAR &&
         state_reg != bfit_pkg::S_RESP) |-> (hidx_reg < eff_k))
        else $error("hash index beyond hash count");

endmodule

`default_nettype wire

// ===== sim/bfit_result_checker.sv =====
// ---------------------------------------------------------------------------
// bfit_result_checker: bloom filter predictor and result scoreboard
// watches the byte and result channels and the register port, keeps its own
// filter image and compares every result transaction with the oldest expected
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module bfit_result_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [bfit_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bfit_pkg::CFG_DATA_W-1:0]  cfg_data,
    bfit_in_if                               byte_ch,
    bfit_out_if                              result_ch,
    output int                               fail_count,
    output int                               pending
);

    typedef struct packed {
        logic [1:0] status;
        logic       op_done;
    } bloom_result_t;

    bloom_result_t expected_results_q[$];

    logic        filter_image [0:(1 << bfit_pkg::DEF_MAX_ARRAY_LOG2) - 1];
    logic [7:0]  value_bytes [0:bfit_pkg::DEF_MAX_VALUE_BYTES - 1];
    int unsigned bytes_held;

    logic [6:0]  size_reg;
    logic [3:0]  hashes_reg;
    logic        sel_reg;
    logic [31:0] seed_reg;
    logic [4:0]  log2_reg;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    // little-endian word, bytes at or past lim read as zero
    function automatic logic [31:0] word_at(input int off, input int lim);
        logic [31:0] w;
        w = '0;
        for (int j = 0; j < 4; j++)
            if (off + j < lim)
                w[8*j +: 8] = value_bytes[off + j];
        return w;
    endfunction

    function automatic logic [31:0] jenkins_hash(input int len, input logic [31:0] init);
        logic [31:0] a, b, c;
        int off, rem;
        a = bfit_pkg::JHASH_INIT + len + init;
        b = a;
        c = a;
        off = 0;
        rem = len;
        while (rem > 12)
        begin
            a += word_at(off, len);
            b += word_at(off + 4, len);
            c += word_at(off + 8, len);
            a -= c; a ^= rotl(c, 4);  c += b;
            b -= a; b ^= rotl(a, 6);  a += c;
            c -= b; c ^= rotl(b, 8);  b += a;
            a -= c; a ^= rotl(c, 16); c += b;
            b -= a; b ^= rotl(a, 19); a += c;
            c -= b; c ^= rotl(b, 4);  b += a;
            rem -= 12;
            off += 12;
        end
        if (rem == 0)
            return c;
        a += word_at(off, len);
        b += word_at(off + 4, len);
        c += word_at(off + 8, len);
        c ^= b; c -= rotl(b, 14);
        a ^= c; a -= rotl(c, 11);
        b ^= a; b -= rotl(a, 25);
        c ^= b; c -= rotl(b, 16);
        a ^= c; a -= rotl(c, 4);
        b ^= a; b -= rotl(a, 14);
        c ^= b; c -= rotl(b, 24);
        return c;
    endfunction

    function automatic logic [31:0] djb2_fmix_hash(input int len, input logic [31:0] start);
        logic [31:0] h;
        h = start;
        for (int i = 0; i < len; i++)
            h = (h << 5) + h + {24'b0, value_bytes[i]};
        h ^= h >> 16;
        h *= bfit_pkg::FMIX_C1;
        h ^= h >> 13;
        h *= bfit_pkg::FMIX_C2;
        h ^= h >> 16;
        return h;
    endfunction

    function automatic int value_len();
        if (size_reg == 0)
            return 1;
        if (size_reg > bfit_pkg::DEF_MAX_VALUE_BYTES)
            return bfit_pkg::DEF_MAX_VALUE_BYTES;
        return int'(size_reg);
    endfunction

    function automatic int unsigned filter_slot(input int i, input int len);
        logic [31:0] h;
        int lg;
        lg = (log2_reg < 6) ? 6 :
             (log2_reg > bfit_pkg::DEF_MAX_ARRAY_LOG2) ? bfit_pkg::DEF_MAX_ARRAY_LOG2
                                                       : int'(log2_reg);
        if (sel_reg == bfit_pkg::HASH_DJB2)
            h = djb2_fmix_hash(len, seed_reg + i * bfit_pkg::GOLDEN);
        else
            h = jenkins_hash(len, seed_reg + i);
        return h & ((32'd1 << lg) - 1);
    endfunction

    // applies one completed value to the filter image, gives its status
    function automatic bloom_result_t bloom_predict(input logic op, input logic [1:0] flags);
        bloom_result_t r;
        int len, k;
        int unsigned slot;
        len = value_len();
        k = (hashes_reg == 0) ? 1 : int'(hashes_reg);
        r.status = bfit_pkg::STATUS_OK;
        r.op_done = op;
        if (op == bfit_pkg::OP_INSERT && flags != 0)
            r.status = bfit_pkg::STATUS_BADFLAGS;
        else
            for (int i = 0; i < k; i++)
            begin
                slot = filter_slot(i, len);
                if (op == bfit_pkg::OP_INSERT)
                    filter_image[slot] = 1'b1;
                else if (!filter_image[slot])
                begin
                    r.status = bfit_pkg::STATUS_ABSENT;
                    break;
                end
            end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        bloom_result_t got, want;
        if (!rst_n)
        begin
            foreach (filter_image[i])
                filter_image[i] = 1'b0;
            bytes_held = 0;
            size_reg   = 7'd4;
            hashes_reg = 4'd3;
            sel_reg    = bfit_pkg::HASH_JENKINS;
            seed_reg   = '0;
            log2_reg   = 5'd16;
            expected_results_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got.status  = result_ch.status;
                got.op_done = result_ch.op_done;
                if (expected_results_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result: status %0d op %0d", got.status,
                                 got.op_done);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_results_q.pop_front();
                    if (got != want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: status exp %0d got %0d, op exp %0d got %0d",
                                     want.status, got.status, want.op_done, got.op_done);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_we)
                case (cfg_index)
                    bfit_pkg::REG_VALUE_SIZE: size_reg   = cfg_data[6:0];
                    bfit_pkg::REG_NUM_HASHES: hashes_reg = cfg_data[3:0];
                    bfit_pkg::REG_HASH_SEL:   sel_reg    = cfg_data[0];
                    bfit_pkg::REG_HASH_SEED:  seed_reg   = cfg_data;
                    bfit_pkg::REG_ARRAY_LOG2: log2_reg   = cfg_data[4:0];
                    default: ;
                endcase
            if (byte_ch.valid && byte_ch.ready)
            begin
                if (bytes_held < bfit_pkg::DEF_MAX_VALUE_BYTES)
                    value_bytes[bytes_held] = byte_ch.value_byte;
                bytes_held++;
                if (bytes_held >= value_len())
                begin
                    bytes_held = 0;
                    expected_results_q.push_back(bloom_predict(byte_ch.op,
                                                               byte_ch.update_flags));
                end
            end
            pending <= expected_results_q.size();
        end
    end

endmodule

// ===== sim/bloom_filter_insert_test_tb.sv =====
// ---------------------------------------------------------------------------
// bloom_filter_insert_test_tb: regression bench for the bloom filter
// drives value bytes and register settings with random idling on both
// channels; the checker beside the block predicts and compares the results
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module bloom_filter_insert_test_tb;

    // cycles with no transaction on either channel before giving up;
    // covers the clearing pass after reset and the slowest completing value
    localparam int WATCHDOG_LIMIT = 300000;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [bfit_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bfit_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    int                               fail_count;
    int                               pending;
    int                               quiet_cycles = 0;
    bit                               gaps_on = 1'b1;
    bit                               stalls_on = 1'b1;
    int                               cur_len = 4;
    logic [511:0]                     inserted_q[$];

    bfit_in_if  byte_ch ();
    bfit_out_if result_ch ();

    bloom_filter_insert_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .byte_ch   (byte_ch),
        .result_ch (result_ch)
    );

    bfit_result_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .byte_ch    (byte_ch),
        .result_ch  (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #2 clk = ~clk;

    // watchdog: any transaction restarts the count
    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("bloom_filter_insert_test regression: fail");
            $finish;
        end
    end

    // result side back-pressure: random stall bursts, then open stretches
    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // one byte transaction; valid stays high afterwards unless a gap follows
    task automatic put_byte(input logic op, input logic [7:0] b, input logic [1:0] flags);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.op           <= op;
        byte_ch.value_byte   <= b;
        byte_ch.update_flags <= flags;
        do
            @(posedge clk);
        while (!byte_ch.ready);
    endtask

    // op and flags only matter on the final byte, earlier ones carry noise
    task automatic send_value(input logic op, input logic [1:0] flags, input logic [511:0] v);
        for (int i = 0; i < cur_len; i++)
            if (i == cur_len - 1)
                put_byte(op, v[8*i +: 8], flags);
            else
                put_byte(1'($urandom), v[8*i +: 8], 2'($urandom));
    endtask

    // block is idle once every result is back and the last bytes have settled;
    // pending is read only once the checker has registered it, so that it includes the value just completed
    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [bfit_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic program_filter(input logic [6:0] size, input logic [3:0] k, input logic sel,
                                  input logic [31:0] seed, input logic [4:0] lg);
        write_reg(bfit_pkg::REG_VALUE_SIZE, {25'b0, size});
        write_reg(bfit_pkg::REG_NUM_HASHES, {28'b0, k});
        write_reg(bfit_pkg::REG_HASH_SEL, {31'b0, sel});
        write_reg(bfit_pkg::REG_HASH_SEED, seed);
        write_reg(bfit_pkg::REG_ARRAY_LOG2, {27'b0, lg});
        cfg_we <= 1'b0;
        // sizes out of range are clamped by the block
        cur_len = (size == 0) ? 1 :
                  (size > bfit_pkg::DEF_MAX_VALUE_BYTES) ? bfit_pkg::DEF_MAX_VALUE_BYTES
                                                         : int'(size);
        inserted_q.delete();
    endtask

    function automatic logic [511:0] fresh_value();
        logic [511:0] v;
        for (int i = 0; i < 16; i++)
            v[32*i +: 32] = $urandom;
        return v;
    endfunction

    // mixed traffic: inserts, some with bad flags, re-tests of inserted values, random tests
    task automatic random_traffic(input int byte_budget);
        logic [511:0] v;
        int sent;
        int pick;
        sent = 0;
        while (sent < byte_budget)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                v = fresh_value();
                if ($urandom_range(0, 7) == 0)
                    send_value(bfit_pkg::OP_INSERT, 2'($urandom_range(1, 3)), v);
                else
                begin
                    send_value(bfit_pkg::OP_INSERT, 2'b00, v);
                    inserted_q.push_back(v);
                end
            end
            else if (pick < 8 && inserted_q.size() != 0)
                send_value(bfit_pkg::OP_TEST, 2'($urandom),
                           inserted_q[$urandom_range(0, inserted_q.size() - 1)]);
            else
                send_value(bfit_pkg::OP_TEST, 2'($urandom), fresh_value());
            sent += cur_len;
        end
    endtask

    initial
    begin
        logic [6:0]  size;
        logic [3:0]  k;
        logic [31:0] seed;
        logic [4:0]  lg;

        byte_ch.valid        = 1'b0;
        byte_ch.op           = bfit_pkg::OP_INSERT;
        byte_ch.value_byte   = '0;
        byte_ch.update_flags = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset settings: extremes of the bytes, every operation,
        // insert rejected for each nonzero flag value and flags on a test
        send_value(bfit_pkg::OP_INSERT, 2'b00, {512{1'b1}});
        send_value(bfit_pkg::OP_TEST, 2'b11, {512{1'b1}});
        send_value(bfit_pkg::OP_TEST, 2'b00, '0);
        send_value(bfit_pkg::OP_INSERT, 2'b01, '0);
        send_value(bfit_pkg::OP_INSERT, 2'b10, '0);
        send_value(bfit_pkg::OP_INSERT, 2'b11, '0);
        send_value(bfit_pkg::OP_TEST, 2'b00, '0);
        drain();

        // directed, clamped settings: zero size and zero hashes, filter below
        // the minimum size, djb2 with an all-ones seed
        program_filter(7'd0, 4'd0, bfit_pkg::HASH_DJB2, 32'hffff_ffff, 5'd0);
        send_value(bfit_pkg::OP_INSERT, 2'b00, {504'b0, 8'ha5});
        send_value(bfit_pkg::OP_TEST, 2'b00, {504'b0, 8'ha5});
        send_value(bfit_pkg::OP_TEST, 2'b00, {504'b0, 8'h5a});
        drain();

        // random phases, extremes of every register folded in
        for (int p = 0; p < 12; p++)
        begin
            case (p)
                2:       size = 7'd127;
                5:       size = 7'd64;
                8:       size = 7'd1;
                default: size = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(13, 30))
                                                             : 7'($urandom_range(1, 12));
            endcase
            case (p % 4)
                0:       k = 4'd15;
                1:       k = 4'd1;
                default: k = 4'($urandom);
            endcase
            case (p % 3)
                0:       seed = '0;
                1:       seed = 32'hffff_ffff;
                default: seed = $urandom;
            endcase
            case (p % 5)
                0:       lg = 5'd6;
                1:       lg = 5'd16;
                2:       lg = 5'd31;
                default: lg = 5'($urandom);
            endcase
            // the last stretch runs with neither side idling
            if (p == 11)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            program_filter(size, k, 1'(p % 2), seed, lg);
            random_traffic(140);
            drain();
        end

        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("bloom_filter_insert_test regression: pass");
        else
            $display("bloom_filter_insert_test regression: fail");
        $finish;
    end

endmodule

// ===== bloom_filter_insert_test.f =====
design/bfit_pkg.sv
design/bfit_in_if.sv
design/bfit_out_if.sv
design/bloom_filter_insert_test.sv
sim/bfit_result_checker.sv
sim/bloom_filter_insert_test_tb.sv
